// ----- rtl/pal_pkg.sv -----
// shared types and constants for the positional array list
`timescale 1ns / 1ps
`default_nettype none
package pal_pkg;

  // field widths of the stream items
  localparam int DATA_W = 32;
  localparam int POS_W = 5;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETRIEVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SORTED = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // one result item as handed from the sequencer to the output stage
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  entries;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/pal_mem.sv -----
// element store: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pal_mem #(
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [pal_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic      [pal_pkg::DATA_W-1:0] rdata
);
  import pal_pkg::*;

  logic [DATA_W-1:0] store [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pal_ctrl.sv -----
// request sequencer: scans and shifts the element store one entry per cycle
`timescale 1ns / 1ps
`default_nettype none
module pal_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [pal_pkg::KIND_W-1:0]        in_kind,
  input  wire logic signed [pal_pkg::DATA_W-1:0] in_value,
  input  wire logic [pal_pkg::POS_W-1:0]         in_position,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output pal_pkg::res_t                          res,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic [pal_pkg::DATA_W-1:0]             mem_wdata,
  output logic                                   mem_re,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic [pal_pkg::DATA_W-1:0]        mem_rdata
);
  import pal_pkg::*;

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_RD, S_RDW, S_DONE
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     tgt;
  logic [CW-1:0]     chk_idx;
  logic [CW-1:0]     wdst;
  logic              chk_valid;
  logic              wpend;
  logic              sort_mode;
  logic [DATA_W-1:0] value_r;
  logic [STAT_W-1:0] st_q;
  logic [DATA_W-1:0] rv_q;
  logic [POS_W-1:0]  fp_q;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_idx;
  logic [CMPW-1:0] chk_pos;
  logic [CMPW-1:0] cnt_inc;
  logic [CMPW-1:0] entries_ext;
  logic [CW-1:0]   ptr_dec;
  logic            pos_ok_ins;
  logic            pos_ok_sel;
  logic            full;
  logic            hit;
  logic            scan_rd;
  logic            up_more;
  logic            dn_more;

  // request checks and position arithmetic
  always_comb begin
    pos_ext = CMPW'(in_position);
    cnt_ext = CMPW'(count);
    pos_idx = pos_ext - 1'b1;
    cnt_inc = cnt_ext + 1'b1;
    chk_pos = CMPW'(chk_idx) + 1'b1;
    entries_ext = CMPW'(count);
    ptr_dec = ptr - 1'b1;
    pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_inc);
    pos_ok_sel = (pos_ext != '0) && (pos_ext <= cnt_ext);
    full = (cnt_ext >= CMPW'(CAPACITY));
    hit = sort_mode ? ($signed(mem_rdata) >= $signed(value_r)) : (mem_rdata == value_r);
    scan_rd = (ptr < count);
    up_more = (ptr > tgt);
    dn_more = (ptr < count);
  end

  // memory access per state
  always_comb begin
    mem_re = 1'b0;
    mem_raddr = ptr[AW-1:0];
    mem_we = 1'b0;
    mem_waddr = wdst[AW-1:0];
    mem_wdata = mem_rdata;
    case (state)
      S_SCAN: begin
        mem_re = scan_rd;
      end
      S_SHUP: begin
        mem_re = up_more;
        mem_raddr = ptr_dec[AW-1:0];
        if (wpend) begin
          mem_we = 1'b1;
        end else if (!up_more) begin
          mem_we = 1'b1;
          mem_waddr = tgt[AW-1:0];
          mem_wdata = value_r;
        end
      end
      S_SHDN: begin
        mem_re = dn_more;
        mem_we = wpend;
      end
      S_RD: begin
        mem_re = 1'b1;
        mem_raddr = tgt[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{status: st_q, read_value: rv_q, found_position: fp_q,
                 entries: entries_ext[POS_W-1:0]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      chk_valid <= 1'b0;
      wpend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            value_r <= in_value;
            sort_mode <= (in_kind == KIND_SORTED);
            st_q <= ST_OK;
            rv_q <= '0;
            fp_q <= '0;
            chk_valid <= 1'b0;
            wpend <= 1'b0;
            case (in_kind)
              KIND_INSERT: begin
                if (!pos_ok_ins) begin
                  st_q <= ST_BADPOS;
                  state <= S_DONE;
                end else if (full) begin
                  st_q <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  tgt <= pos_idx[CW-1:0];
                  ptr <= count;
                  fp_q <= in_position;
                  state <= S_SHUP;
                end
              end
              KIND_DELETE: begin
                if (!pos_ok_sel) begin
                  st_q <= ST_BADPOS;
                  state <= S_DONE;
                end else begin
                  ptr <= pos_ext[CW-1:0];
                  state <= S_SHDN;
                end
              end
              KIND_LOCATE: begin
                ptr <= '0;
                state <= S_SCAN;
              end
              KIND_RETRIEVE: begin
                if (!pos_ok_sel) begin
                  st_q <= ST_BADPOS;
                  state <= S_DONE;
                end else begin
                  tgt <= pos_idx[CW-1:0];
                  state <= S_RD;
                end
              end
              KIND_SORTED: begin
                if (full) begin
                  st_q <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  ptr <= '0;
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        // read entries in order, compare each in the cycle after its read
        S_SCAN: begin
          chk_valid <= scan_rd;
          chk_idx <= ptr;
          if (scan_rd) begin
            ptr <= ptr + 1'b1;
          end
          if (chk_valid && hit) begin
            chk_valid <= 1'b0;
            fp_q <= chk_pos[POS_W-1:0];
            if (sort_mode) begin
              tgt <= chk_idx;
              ptr <= count;
              wpend <= 1'b0;
              state <= S_SHUP;
            end else begin
              state <= S_DONE;
            end
          end else if (!chk_valid && !scan_rd) begin
            if (sort_mode) begin
              tgt <= count;
              ptr <= count;
              wpend <= 1'b0;
              fp_q <= cnt_inc[POS_W-1:0];
              state <= S_SHUP;
            end else begin
              st_q <= ST_NOTFOUND;
              state <= S_DONE;
            end
          end
        end
        // move entries up from the top, then write the new value
        S_SHUP: begin
          wpend <= up_more;
          wdst <= ptr;
          if (up_more) begin
            ptr <= ptr_dec;
          end
          if (!wpend && !up_more) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        // move entries down from the gap
        S_SHDN: begin
          wpend <= dn_more;
          wdst <= ptr_dec;
          if (dn_more) begin
            ptr <= ptr + 1'b1;
          end
          if (!wpend && !dn_more) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          rv_q <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + 1'b1) ||
             (count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_full_means_capacity: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_FULL) |-> (CMPW'(count) == CMPW'(CAPACITY)))
    else $error("full status with room left");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted item did not occupy the sequencer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ready || res_valid) |-> !mem_we)
    else $error("store written outside a request");

endmodule
`default_nettype wire

// ----- rtl/positional_array_list_core.sv -----
// Positional array list: a rejected or unknown request goes straight to its result; retrieve reads
// entry p; insert at p shifts entries p and above up, then writes the value; delete at p shifts the
// entries above p down; locate scans from the first entry to a match; sorted insert scans for the
// first entry not below the value and inserts there or at the end; a stalled output adds its stall.
// One item is worked at a time, the next taken in the cycle after a result enters the output
// register. Reset clears the entry count; store contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module positional_array_list_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pal_pkg::S_TDATA_W-1:0] s_tdata, // value[31:0], position[36:32]
  input  wire logic [pal_pkg::S_TUSER_W-1:0] s_tuser, // kind[2:0]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pal_pkg::M_TDATA_W-1:0]      m_tdata, // read_value[31:0],
                                                      // found_position[36:32], entries[41:37]
  output logic [pal_pkg::M_TUSER_W-1:0]      m_tuser  // status[1:0]
);
  import pal_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  pal_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_kind(s_tuser[KIND_W-1:0]),
    .in_value(s_tdata[DATA_W-1:0]),
    .in_position(s_tdata[DATA_W+POS_W-1:DATA_W]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  pal_mem #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register: takes a result whenever it is empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {{(M_TDATA_W - DATA_W - 2*POS_W){1'b0}}, res.entries,
                  res.found_position, res.read_value};
      m_tuser <= {{(M_TUSER_W - STAT_W){1'b0}}, res.status};
    end
  end

endmodule
`default_nettype wire
